/* design/bspq_pkg.sv */
package bspq_pkg;

    // reset value of the capacity register, also used when it holds zero
    localparam int unsigned DEFAULT_CAPACITY = 64;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    // one slot of the job store
    typedef struct packed {
        logic        valid;
        logic [15:0] prio;
        logic [31:0] seq;
        logic [15:0] tag;
    } entry_t;

endpackage

/* design/bspq_ram.sv */
module bspq_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/bounded_stable_priority_queue.sv */
// bounded job queue with priority service
// input channel (s_*): one word per request; s_tuser is the operation
// (enqueue or dequeue), s_tdata carries the job priority and tag
// result channel (m_*): exactly one word per request with the status in
// m_tuser and tag, priority, sequence stamp and occupancy in m_tdata
// config channel (cfg_*): writes the queue capacity, zero meaning 64, and
// values above QUEUE_DEPTH acting as QUEUE_DEPTH; write only while idle
// jobs live in a single-port-read memory of QUEUE_DEPTH slots; one shared
// compare unit walks the slots one per cycle behind the registered read
// a dequeue scans every slot
// an enqueue scans up to the lowest free slot
// a rejected enqueue or an empty dequeue goes straight to the done state
// s_tready is high only while the sequencer is idle
// after reset a clearing pass through every slot empties the memory;
// no request is taken during it, config writes are
// the result sits in an output register, so a stalled receiver holds only
// the next finished result; the queue waits in its done state meanwhile
module bounded_stable_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,    // queue_capacity
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] job_priority, [31:16] job_tag
    input  logic [0:0]  s_tuser,     // [0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // [15:0] out_tag, [31:16] out_priority,
                                     // [63:32] out_sequence, [70:64] occupancy
    output logic [1:0]  m_tuser      // [1:0] status
);

    import bspq_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [15:0]        prio_reg, prio_next;
    logic [15:0]        tag_reg, tag_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        seq_reg, seq_next;
    logic [6:0]         cap_reg, cap_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic               issue_done_reg, issue_done_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    entry_t             best_reg, best_next;
    status_t            res_status_reg, res_status_next;
    logic [15:0]        res_tag_reg, res_tag_next;
    logic [15:0]        res_prio_reg, res_prio_next;
    logic [31:0]        res_seq_reg, res_seq_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    // memory port
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    entry_t             rd_entry;

    logic               in_accept;
    logic               out_free;
    logic [CAP_W-1:0]   cap_raw;
    logic [CAP_W-1:0]   cap_eff;
    logic               full;
    logic               better;

    bspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (addr_reg),
        .rd_data (rd_word)
    );

    assign rd_entry  = entry_t'(rd_word);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // effective capacity: zero means the default, clipped to the depth
    assign cap_raw = (cap_reg == 7'd0) ? CAP_W'(DEFAULT_CAPACITY) : CAP_W'(cap_reg);
    assign cap_eff = (cap_raw > CAP_W'(QUEUE_DEPTH)) ? CAP_W'(QUEUE_DEPTH) : cap_raw;
    assign full    = CAP_W'(count_reg) >= cap_eff;

    // shared compare unit: higher priority (compared as signed) wins, oldest stamp on a tie
    assign better = ($signed(rd_entry.prio) > $signed(best_reg.prio)) ||
                    ((rd_entry.prio == best_reg.prio) && (rd_entry.seq < best_reg.seq));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (op_t'(s_tuser[0]) == OP_ENQUEUE) begin
                        state_next = full ? S_DONE : S_SCAN;
                    end else begin
                        state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (pend_reg) begin
                    if (op_reg == OP_ENQUEUE) begin
                        if (!rd_entry.valid) begin
                            state_next = S_WRITE;
                        end
                    end else if (pend_idx_reg == LAST_IDX) begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next         = op_reg;
        prio_next       = prio_reg;
        tag_next        = tag_reg;
        count_next      = count_reg;
        seq_next        = seq_reg;
        cap_next        = cfg_valid ? cfg_data : cap_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pend_idx_next   = addr_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_prio_next   = res_prio_reg;
        res_seq_next    = res_seq_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_entry        = '0;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
            end
            S_IDLE: begin
                if (in_accept) begin
                    op_next         = op_t'(s_tuser[0]);
                    prio_next       = s_tdata[15:0];
                    tag_next        = s_tdata[31:16];
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    res_tag_next    = '0;
                    res_prio_next   = '0;
                    res_seq_next    = '0;
                    res_status_next = (op_t'(s_tuser[0]) == OP_ENQUEUE) ? ST_REJECTED
                                                                        : ST_EMPTY;
                end
            end
            S_SCAN: begin
                // issue one read per cycle
                if (!issue_done_reg) begin
                    pend_next       = 1'b1;
                    issue_done_next = (addr_reg == LAST_IDX);
                    addr_next       = (addr_reg == LAST_IDX) ? addr_reg : addr_reg + 1'b1;
                end
                // consume the word read in the previous cycle
                if (pend_reg) begin
                    if (op_reg == OP_ENQUEUE) begin
                        if (!found_reg && !rd_entry.valid) begin
                            found_next    = 1'b1;
                            best_idx_next = pend_idx_reg;
                        end
                    end else if (rd_entry.valid && (!found_reg || better)) begin
                        found_next    = 1'b1;
                        best_idx_next = pend_idx_reg;
                        best_next     = rd_entry;
                    end
                end
            end
            S_WRITE: begin
                wr_en = 1'b1;
                if (op_reg == OP_ENQUEUE) begin
                    wr_entry.valid  = 1'b1;
                    wr_entry.prio   = prio_reg;
                    wr_entry.seq    = seq_reg;
                    wr_entry.tag    = tag_reg;
                    res_status_next = ST_ENQUEUED;
                    res_seq_next    = seq_reg;
                    seq_next        = seq_reg + 32'd1;
                    count_next      = count_reg + 1'b1;
                end else begin
                    res_status_next = ST_DEQUEUED;
                    res_tag_next    = best_reg.tag;
                    res_prio_next   = best_reg.prio;
                    res_seq_next    = best_reg.seq;
                    count_next      = count_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {1'b0, 7'(count_reg), res_seq_reg,
                                     res_prio_reg, res_tag_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            count_reg      <= '0;
            seq_reg        <= '0;
            cap_reg        <= 7'(DEFAULT_CAPACITY);
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            seq_reg        <= seq_next;
            cap_reg        <= cap_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        prio_reg       <= prio_next;
        tag_reg        <= tag_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_prio_reg   <= res_prio_next;
        res_seq_reg    <= res_seq_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // occupancy never goes beyond the number of slots
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

    // a slot is only written back once the scan has picked one
    a_write_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WRITE |-> found_reg)
        else $error("write without a chosen slot");

    // the stamp advances only when a job is actually stored
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(seq_reg) |->
            $past(state_reg == S_WRITE && op_reg == OP_ENQUEUE))
        else $error("sequence moved without an enqueue");

    // a new result appears only from the done state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

endmodule
